@@ rtl/core/gamma_lut_luma_gray_converter_assert.svh @@
// Assertion macros shared by the gray converter RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef GAMMA_LUT_LUMA_GRAY_CONVERTER_ASSERT_SVH
`define GAMMA_LUT_LUMA_GRAY_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GLG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gray converter check failed");

// Next-cycle implication, checked outside reset.
`define GLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gray converter check failed");

`endif

@@ rtl/core/glg_pkg.sv @@
// Shared types and constants of the gray converter.
// No dependencies; used by every module in rtl/core.
package glg_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_IN  = 2'd0,
    REQ_LOAD_OUT = 2'd1,
    REQ_PIXEL    = 2'd2,
    REQ_FINAL    = 2'd3
  } glg_req_t;

  localparam logic RES_PIXEL = 1'b0;
  localparam logic RES_FINAL = 1'b1;

  localparam logic [2:0] REG_RED_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_GREEN_WEIGHT  = 3'd1;
  localparam logic [2:0] REG_BLUE_WEIGHT   = 3'd2;
  localparam logic [2:0] REG_LINEAR_MODE   = 3'd3;
  localparam logic [2:0] REG_INVERT_OUTPUT = 3'd4;
  localparam logic [2:0] REG_SINGLE_CHAN   = 3'd5;

  localparam logic [15:0] RED_WEIGHT_RST   = 16'd6967;
  localparam logic [15:0] GREEN_WEIGHT_RST = 16'd23436;
  localparam logic [15:0] BLUE_WEIGHT_RST  = 16'd2365;

  localparam int Q_SHIFT = 15;
  localparam logic [7:0] BYTE_MAX = 8'd255;
  localparam logic [15:0] WORD_MAX = 16'hFFFF;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [15:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr_r;
    logic [7:0] rd_addr_g;
    logic [7:0] rd_addr_b;
  } glg_ic_req_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr;
  } glg_oc_req_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } glg_adv_t;

  typedef struct packed {
    glg_req_t    kind;
    logic        row_end;
    logic [15:0] avg;
    logic [7:0]  tidx;
    logic [7:0]  tval;
  } glg_meta_t;

endpackage

@@ rtl/core/glg_in_curve.sv @@
// Input curve storage: three identical copies of the 256 x 16 table, one per color read.
// Depends on glg_pkg.
module glg_in_curve (
  input  logic               clk,
  input  glg_pkg::glg_ic_req_t req,
  output logic [15:0]        rd_data_r,
  output logic [15:0]        rd_data_g,
  output logic [15:0]        rd_data_b
);
  import glg_pkg::*;

  logic [15:0] mem_r [256];
  logic [15:0] mem_g [256];
  logic [15:0] mem_b [256];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
      mem_g[req.wr_addr] <= req.wr_data;
      mem_b[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr_r];
      rd_data_g <= mem_g[req.rd_addr_g];
      rd_data_b <= mem_b[req.rd_addr_b];
    end
  end

endmodule

@@ rtl/core/glg_luma.sv @@
// Weighted luma datapath: Q15 products, sum, shift and saturation over two stages; single_channel passes red.
// Depends on glg_pkg.
module glg_luma (
  input  logic             clk,
  input  glg_pkg::glg_adv_t adv,
  input  logic [15:0]      curve_r,
  input  logic [15:0]      curve_g,
  input  logic [15:0]      curve_b,
  input  logic [15:0]      red_weight,
  input  logic [15:0]      green_weight,
  input  logic [15:0]      blue_weight,
  input  logic             single_channel,
  output logic [15:0]      lum
);
  import glg_pkg::*;

  logic [31:0] prod_r_r;
  logic [31:0] prod_g_r;
  logic [31:0] prod_b_r;
  logic [15:0] mono_r;
  logic [15:0] lum_r;
  logic [33:0] sum;
  logic [18:0] shifted;
  logic [15:0] lum_nxt;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod_r_r <= red_weight * curve_r;
      prod_g_r <= green_weight * curve_g;
      prod_b_r <= blue_weight * curve_b;
      mono_r   <= curve_r;
    end
  end

  always_comb begin
    sum     = {2'b00, prod_r_r} + {2'b00, prod_g_r} + {2'b00, prod_b_r};
    shifted = sum[33:Q_SHIFT];
    if (single_channel) begin
      lum_nxt = mono_r;
    end else if (|shifted[18:16]) begin
      lum_nxt = WORD_MAX;
    end else begin
      lum_nxt = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      lum_r <= lum_nxt;
    end
  end

  assign lum = lum_r;

endmodule

@@ rtl/core/glg_out_curve.sv @@
// Output curve storage: one 256 x 8 table with a registered read port.
// Depends on glg_pkg.
module glg_out_curve (
  input  logic               clk,
  input  glg_pkg::glg_oc_req_t req,
  output logic [7:0]         rd_data
);
  import glg_pkg::*;

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/core/gamma_lut_luma_gray_converter.sv @@
// Pixel and finalize items reach out_valid through stage registers and the output register.
// One item per cycle unless out_stall backs up; a table load also reads its curve copy.
// Stages advance independently, so input is taken while a result waits in the output register.
// Reset clears stage valids and configuration registers; the curve tables are not cleared.
// Depends on glg_pkg, glg_in_curve, glg_luma, glg_out_curve and the assertion header.
`include "gamma_lut_luma_gray_converter_assert.svh"

module gamma_lut_luma_gray_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_value,
  input  logic [7:0]  in_red_sample,
  input  logic [7:0]  in_green_sample,
  input  logic [7:0]  in_blue_sample,
  input  logic [15:0] in_average_value,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [15:0] out_intensity,
  output logic [7:0]  out_gray_level,
  output logic        out_row_end_out
);
  import glg_pkg::*;

  logic [15:0] red_weight_r;
  logic [15:0] green_weight_r;
  logic [15:0] blue_weight_r;
  logic        linear_mode_r;
  logic        invert_output_r;
  logic        single_channel_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic ld1, ld2, ld3, ld4, ld5;
  logic free1, free2, free3, free4;

  glg_meta_t meta_in, meta1_r, meta2_r, meta3_r, meta4_r;
  logic [15:0] lum4_r;

  glg_ic_req_t ic_req;
  glg_oc_req_t oc_req;
  glg_adv_t    adv;
  logic [15:0] curve_r, curve_g, curve_b;
  logic [15:0] lum3;
  logic [7:0]  ocur4;

  logic        kind_nxt;
  logic [15:0] intensity_nxt;
  logic [7:0]  gray_nxt;
  logic        row_end_nxt;
  logic [7:0]  clamp_byte;
  logic [7:0]  fin_byte;

  logic        out_kind_r;
  logic [15:0] out_intensity_r;
  logic [7:0]  out_gray_r;
  logic        out_row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_weight_r     <= RED_WEIGHT_RST;
      green_weight_r   <= GREEN_WEIGHT_RST;
      blue_weight_r    <= BLUE_WEIGHT_RST;
      linear_mode_r    <= 1'b0;
      invert_output_r  <= 1'b0;
      single_channel_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_WEIGHT:    red_weight_r     <= cfg_wdata;
        REG_GREEN_WEIGHT:  green_weight_r   <= cfg_wdata;
        REG_BLUE_WEIGHT:   blue_weight_r    <= cfg_wdata;
        REG_LINEAR_MODE:   linear_mode_r    <= cfg_wdata[0];
        REG_INVERT_OUTPUT: invert_output_r  <= cfg_wdata[0];
        REG_SINGLE_CHAN:   single_channel_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ld5   = v4_r && !(out_valid_r && out_stall);
    free4 = !v4_r || ld5;
    ld4   = v3_r && free4;
    free3 = !v3_r || ld4;
    ld3   = v2_r && free3;
    free2 = !v2_r || ld3;
    ld2   = v1_r && free2;
    free1 = !v1_r || ld2;
    ld1   = in_valid && free1;

    v1_nxt = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_r);
    v3_nxt = ld3 ? 1'b1 : (ld4 ? 1'b0 : v3_r);
    v4_nxt = ld4 ? 1'b1 : (ld5 ? 1'b0 : v4_r);
    if (ld5) begin
      out_valid_nxt = meta4_r.kind == REQ_PIXEL || meta4_r.kind == REQ_FINAL;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = !free1;

  always_comb begin
    meta_in.kind    = glg_req_t'(in_req_type);
    meta_in.row_end = in_row_end;
    meta_in.avg     = in_average_value;
    meta_in.tidx    = in_table_index;
    meta_in.tval    = in_table_value[7:0];
  end

  always_ff @(posedge clk) begin
    if (ld1) meta1_r <= meta_in;
    if (ld2) meta2_r <= meta1_r;
    if (ld3) meta3_r <= meta2_r;
    if (ld4) meta4_r <= meta3_r;
    if (ld4) lum4_r  <= lum3;
  end

  always_comb begin
    ic_req.wr_en     = ld1 && meta_in.kind == REQ_LOAD_IN;
    ic_req.wr_addr   = in_table_index;
    ic_req.wr_data   = in_table_value;
    ic_req.rd_en     = ld1;
    ic_req.rd_addr_r = in_red_sample;
    ic_req.rd_addr_g = in_green_sample;
    ic_req.rd_addr_b = in_blue_sample;

    adv.s2 = ld2;
    adv.s3 = ld3;

    oc_req.wr_en   = ld4 && meta3_r.kind == REQ_LOAD_OUT;
    oc_req.wr_addr = meta3_r.tidx;
    oc_req.wr_data = meta3_r.tval;
    oc_req.rd_en   = ld4;
    oc_req.rd_addr = (meta3_r.kind == REQ_PIXEL) ? lum3[15:8] : meta3_r.avg[15:8];
  end

  glg_in_curve u_in_curve (
    .clk       (clk),
    .req       (ic_req),
    .rd_data_r (curve_r),
    .rd_data_g (curve_g),
    .rd_data_b (curve_b)
  );

  glg_luma u_luma (
    .clk            (clk),
    .adv            (adv),
    .curve_r        (curve_r),
    .curve_g        (curve_g),
    .curve_b        (curve_b),
    .red_weight     (red_weight_r),
    .green_weight   (green_weight_r),
    .blue_weight    (blue_weight_r),
    .single_channel (single_channel_r),
    .lum            (lum3)
  );

  glg_out_curve u_out_curve (
    .clk     (clk),
    .req     (oc_req),
    .rd_data (ocur4)
  );

  always_comb begin
    clamp_byte = (|meta4_r.avg[15:8]) ? BYTE_MAX : meta4_r.avg[7:0];
    fin_byte   = linear_mode_r ? ocur4 : clamp_byte;
    if (meta4_r.kind == REQ_FINAL) begin
      kind_nxt      = RES_FINAL;
      intensity_nxt = 16'd0;
      gray_nxt      = invert_output_r ? (BYTE_MAX - fin_byte) : fin_byte;
      row_end_nxt   = 1'b0;
    end else begin
      kind_nxt      = RES_PIXEL;
      intensity_nxt = linear_mode_r ? lum4_r : {8'h00, ocur4};
      gray_nxt      = 8'd0;
      row_end_nxt   = meta4_r.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_kind_r      <= kind_nxt;
      out_intensity_r <= intensity_nxt;
      out_gray_r      <= gray_nxt;
      out_row_end_r   <= row_end_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_intensity   = out_intensity_r;
  assign out_gray_level  = out_gray_r;
  assign out_row_end_out = out_row_end_r;

  `GLG_ASSERT_NOW(a_full_pipe_stalls, v1_r && v2_r && v3_r && v4_r && !ld5, in_stall)
  `GLG_ASSERT_NEXT(a_result_reaches_out, ld5 && meta4_r.kind == REQ_FINAL, out_valid_r && out_kind_r)
  `GLG_ASSERT_NEXT(a_loads_make_no_result, ld5 && meta4_r.kind == REQ_LOAD_IN, !out_valid_r)
  `GLG_ASSERT_NOW(a_pixel_gray_zero, out_valid_r && out_result_kind == RES_PIXEL, out_gray_level == 8'd0)
  `GLG_ASSERT_NOW(a_final_fields_zero, out_valid_r && out_kind_r, out_intensity == 16'd0 && !out_row_end_out)

endmodule
